### hdl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int DEFAULT_OPERAND_WIDTH = 32;
    localparam int DATA_WIDTH            = 32;
    localparam int ADDR_WIDTH            = 4;

    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;

    localparam logic TAG_BASE = 1'b0;
    localparam logic TAG_ACC  = 1'b1;

    typedef struct packed {
        logic valid;
        logic tag;
    } mexp_ctl_t;

endpackage

### hdl/modular_exponentiation_core.sv
`timescale 1ns / 1ps
// channel   | ports                               | handshake
// ----------+-------------------------------------+------------------------------
// input     | action, message                     | start high while busy low
// result    | power_result                        | done strobe, one cycle
// config    | psel penable pwrite paddr pwdata    | APB, pready always high
//
// An item first passes the message once through the W-cell modular multiplier
// chain (one cell a bit), then squares the base for each significant exponent bit
// and multiplies the accumulator by the base for each set one, right to left.
// A modulus of 0 or 1 gives a result of 0 without using the chain.
// Reset sets the config registers to 1 and the sequencer to idle.
// The receiver cannot stall; each result beat is shown for one cycle only.

module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  action,
    input  logic [DATA_WIDTH-1:0] message,
    output logic                  done,
    output logic [DATA_WIDTH-1:0] power_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_WIDTH-1:0] paddr,
    input  logic [DATA_WIDTH-1:0] pwdata,
    output logic [DATA_WIDTH-1:0] prdata,
    output logic                  pready
);

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [2:0] {ST_IDLE, ST_SQ, ST_MUL, ST_WAIT} state_t;

    state_t                state_reg;
    logic [DATA_WIDTH-1:0] modulus_reg;
    logic [DATA_WIDTH-1:0] pub_exp_reg;
    logic [DATA_WIDTH-1:0] priv_exp_reg;
    logic [W-1:0]          e_reg;
    logic [W-1:0]          base_reg;
    logic [W-1:0]          acc_reg;
    logic [1:0]            pend_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    mexp_ctl_t             inj_ctl_reg;
    logic [W-1:0]          inj_a_reg;
    logic [W-1:0]          inj_b_reg;

    logic [W-1:0]          m_w;
    logic                  accept;
    logic                  wr;
    logic                  ret_valid;

    mexp_ctl_t             ctl_c [W+1];
    logic [W-1:0]          acc_c [W+1];
    logic [W-1:0]          a_c   [W+1];
    logic [W-1:0]          b_c   [W+1];

    assign m_w    = modulus_reg[W-1:0];
    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[3:2])
            REG_MODULUS:     prdata = modulus_reg;
            REG_PUBLIC_EXP:  prdata = pub_exp_reg;
            REG_PRIVATE_EXP: prdata = priv_exp_reg;
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg  <= 32'd1;
            pub_exp_reg  <= 32'd1;
            priv_exp_reg <= 32'd1;
        end
        else if (wr)
        begin
            case (paddr[3:2])
                REG_MODULUS:     modulus_reg  <= pwdata;
                REG_PUBLIC_EXP:  pub_exp_reg  <= pwdata;
                REG_PRIVATE_EXP: priv_exp_reg <= pwdata;
                default:         ;
            endcase
        end
    end

    assign ctl_c[0] = inj_ctl_reg;
    assign acc_c[0] = '0;
    assign a_c[0]   = inj_a_reg;
    assign b_c[0]   = inj_b_reg;

    for (genvar i = 0; i < W; i++)
    begin : g_cell
        mexp_cell #(.W(W)) u_cell
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .m       (m_w),
            .ctl_in  (ctl_c[i]),
            .acc_in  (acc_c[i]),
            .a_in    (a_c[i]),
            .b_in    (b_c[i]),
            .ctl_out (ctl_c[i+1]),
            .acc_out (acc_c[i+1]),
            .a_out   (a_c[i+1]),
            .b_out   (b_c[i+1])
        );
    end

    assign ret_valid = ctl_c[W].valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pend_reg    <= '0;
            done_reg    <= 1'b0;
            inj_ctl_reg <= '0;
            result_reg  <= '0;
            e_reg       <= '0;
            base_reg    <= '0;
            acc_reg     <= '0;
            inj_a_reg   <= '0;
            inj_b_reg   <= '0;
        end
        else
        begin
            done_reg          <= 1'b0;
            inj_ctl_reg.valid <= 1'b0;
            if (ret_valid)
            begin
                pend_reg <= pend_reg - 2'd1;
                if (ctl_c[W].tag == TAG_ACC)
                begin
                    acc_reg <= acc_c[W];
                end
                else
                begin
                    base_reg <= acc_c[W];
                end
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (m_w <= W'(1))
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= '0;
                        end
                        else
                        begin
                            e_reg       <= action ? priv_exp_reg[W-1:0] : pub_exp_reg[W-1:0];
                            acc_reg     <= W'(1);
                            inj_ctl_reg <= '{valid: 1'b1, tag: TAG_BASE};
                            inj_a_reg   <= message[W-1:0];
                            inj_b_reg   <= W'(1);
                            pend_reg    <= 2'd1;
                            state_reg   <= ST_WAIT;
                        end
                    end
                end
                ST_SQ:
                begin
                    inj_ctl_reg <= '{valid: 1'b1, tag: TAG_BASE};
                    inj_a_reg   <= base_reg;
                    inj_b_reg   <= base_reg;
                    pend_reg    <= pend_reg + 2'd1;
                    state_reg   <= ST_MUL;
                end
                ST_MUL:
                begin
                    if (e_reg[0])
                    begin
                        inj_ctl_reg <= '{valid: 1'b1, tag: TAG_ACC};
                        inj_a_reg   <= acc_reg;
                        inj_b_reg   <= base_reg;
                        pend_reg    <= pend_reg + 2'd1;
                    end
                    e_reg     <= e_reg >> 1;
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (pend_reg == 2'd0)
                    begin
                        if (e_reg == '0)
                        begin
                            done_reg   <= 1'b1;
                            result_reg <= DATA_WIDTH'(acc_reg);
                            state_reg  <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_SQ;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign done         = done_reg;
    assign power_result = result_reg;

endmodule

### hdl/mexp_cell.sv
`timescale 1ns / 1ps

module mexp_cell
    import mexp_pkg::*;
#(
    parameter int W = DEFAULT_OPERAND_WIDTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [W-1:0] m,
    input  mexp_ctl_t    ctl_in,
    input  logic [W-1:0] acc_in,
    input  logic [W-1:0] a_in,
    input  logic [W-1:0] b_in,
    output mexp_ctl_t    ctl_out,
    output logic [W-1:0] acc_out,
    output logic [W-1:0] a_out,
    output logic [W-1:0] b_out
);

    mexp_ctl_t    ctl_reg;
    logic [W-1:0] acc_reg;
    logic [W-1:0] a_reg;
    logic [W-1:0] b_reg;
    logic [W-1:0] acc_next;
    logic [W:0]   dbl;
    logic [W:0]   dbl_red;
    logic [W:0]   sum;
    logic [W:0]   sum_red;

    always_comb
    begin
        dbl     = {acc_in, 1'b0};
        dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        sum     = dbl_red + (a_in[W-1] ? {1'b0, b_in} : {(W+1){1'b0}});
        sum_red = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
        acc_next = sum_red[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= {a_in[W-2:0], 1'b0};
        b_reg   <= b_in;
    end

    assign ctl_out = ctl_reg;
    assign acc_out = acc_reg;
    assign a_out   = a_reg;
    assign b_out   = b_reg;

endmodule

### hdl/mexp_checker.sv
`timescale 1ns / 1ps

module mexp_checker
    import mexp_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done,
    input logic pready
);

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted beat neither worked nor answered");

    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result beat");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy || start))
        else $error("result beat without an accepted item");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .pready (pready)
);
